// File: hw/rtl/iae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iae_pkg
// Shared constants, action and status codes, and the controller/datapath
// command and status types of the indexed array engine.
// ----------------------------------------------------------------------------
package iae_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int WORD_W       = 32;
    localparam int IDX_W        = 10;
    localparam int ACT_W        = 4;
    localparam int CNT_OUT_W    = 11;
    localparam int STAT_W       = 3;

    localparam logic [ACT_W-1:0] ACT_PUSH    = 4'd0;
    localparam logic [ACT_W-1:0] ACT_POP     = 4'd1;
    localparam logic [ACT_W-1:0] ACT_GET     = 4'd2;
    localparam logic [ACT_W-1:0] ACT_SET     = 4'd3;
    localparam logic [ACT_W-1:0] ACT_INSERT  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_DELETE  = 4'd5;
    localparam logic [ACT_W-1:0] ACT_REVERSE = 4'd6;
    localparam logic [ACT_W-1:0] ACT_ROTATE  = 4'd7;
    localparam logic [ACT_W-1:0] ACT_SEARCH  = 4'd8;
    localparam logic [ACT_W-1:0] ACT_SUMMARY = 4'd9;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE   = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISSING = 3'd4;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_PUSH, OP_RD_TOP, OP_RD_IDX, OP_TAKE, OP_SET,
        OP_INS_INIT, OP_INS_RD, OP_INS_WR, OP_INS_FIN,
        OP_DEL_INIT, OP_DEL_RD, OP_DEL_WR, OP_DEL_FIN,
        OP_ROT_RD0, OP_ROT_SAVE, OP_ROT_FIN,
        OP_REV_INIT, OP_REV_RDA, OP_REV_RDB, OP_REV_WRA, OP_REV_WRB,
        OP_SRCH_INIT, OP_SRCH_RD, OP_SRCH_CMP,
        OP_SUM_INIT, OP_SUM_RD, OP_DONE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [STAT_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             empty;
        logic             full;
        logic             idx_ge;
        logic             idx_gt;
        logic             cnt_gt1;
        logic             ins_more;
        logic             del_more;
        logic             rev_more;
        logic             srch_more;
        logic             sum_more;
        logic             key_eq;
    } t_stat;

endpackage

// File: hw/rtl/iae_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iae_dp
// Datapath: word memory (one write, one registered read per cycle), count,
// walk pointers, search bounds, summary accumulators and result registers.
// ----------------------------------------------------------------------------
module iae_dp #(
    parameter int CAPACITY = iae_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  iae_pkg::t_cmd                       i_cmd,
    input  logic [iae_pkg::ACT_W-1:0]           i_action,
    input  logic [iae_pkg::IDX_W-1:0]           i_index,
    input  logic signed [iae_pkg::WORD_W-1:0]   i_value,
    output iae_pkg::t_stat                      o_stat,
    output logic                                o_done,
    output logic signed [iae_pkg::WORD_W-1:0]   o_result_value,
    output logic [iae_pkg::IDX_W-1:0]           o_found_index,
    output logic [iae_pkg::CNT_OUT_W-1:0]       o_item_count,
    output logic signed [iae_pkg::WORD_W-1:0]   o_smallest,
    output logic signed [iae_pkg::WORD_W-1:0]   o_largest,
    output logic signed [iae_pkg::WORD_W-1:0]   o_total,
    output logic                                o_is_sorted,
    output logic [iae_pkg::STAT_W-1:0]          o_status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > iae_pkg::IDX_W) ? CW : iae_pkg::IDX_W) + 1;
    localparam int WW = iae_pkg::WORD_W;

    logic signed [WW-1:0] r_mem [CAPACITY];
    logic signed [WW-1:0] r_rdata;

    logic [iae_pkg::ACT_W-1:0] r_action;
    logic [XW-1:0]             r_idx;
    logic signed [WW-1:0]      r_val;
    logic [CW-1:0]             r_cnt;
    logic [XW-1:0]             r_ptr, r_b, r_lo, r_hi, r_mid;
    logic signed [WW-1:0]      r_tmp, r_prev;
    logic                      r_acc_pend, r_first, r_done;

    logic signed [WW-1:0]        r_rv, r_min, r_max, r_sum;
    logic [iae_pkg::IDX_W-1:0]   r_found;
    logic                        r_sorted;
    logic [iae_pkg::STAT_W-1:0]  r_status;

    logic [XW-1:0]        cnt_x, mid_c;
    logic                 rd_en, wr_en;
    logic [XW-1:0]        rd_addr, wr_addr;
    logic signed [WW-1:0] wr_data;

    assign cnt_x = XW'(r_cnt);
    assign mid_c = r_lo + ((r_hi - r_lo - XW'(1)) >> 1);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_ptr;
        wr_en   = 1'b0;
        wr_addr = r_ptr;
        wr_data = r_rdata;
        case (i_cmd.op)
            iae_pkg::OP_PUSH: begin
                wr_en = 1'b1; wr_addr = cnt_x; wr_data = r_val;
            end
            iae_pkg::OP_RD_TOP: begin
                rd_en = 1'b1; rd_addr = cnt_x - XW'(1);
            end
            iae_pkg::OP_RD_IDX: begin
                rd_en = 1'b1; rd_addr = r_idx;
            end
            iae_pkg::OP_SET, iae_pkg::OP_INS_FIN: begin
                wr_en = 1'b1; wr_addr = r_idx; wr_data = r_val;
            end
            iae_pkg::OP_INS_RD: begin
                rd_en = 1'b1; rd_addr = r_ptr - XW'(1);
            end
            iae_pkg::OP_INS_WR, iae_pkg::OP_DEL_WR, iae_pkg::OP_REV_WRA: begin
                wr_en = 1'b1;
            end
            iae_pkg::OP_DEL_RD: begin
                rd_en = 1'b1; rd_addr = r_ptr + XW'(1);
            end
            iae_pkg::OP_ROT_RD0: begin
                rd_en = 1'b1; rd_addr = '0;
            end
            iae_pkg::OP_ROT_FIN: begin
                wr_en = 1'b1; wr_addr = cnt_x - XW'(1); wr_data = r_tmp;
            end
            iae_pkg::OP_REV_RDA, iae_pkg::OP_SUM_RD: begin
                rd_en = 1'b1;
            end
            iae_pkg::OP_REV_RDB: begin
                rd_en = 1'b1; rd_addr = r_b;
            end
            iae_pkg::OP_REV_WRB: begin
                wr_en = 1'b1; wr_addr = r_b; wr_data = r_tmp;
            end
            iae_pkg::OP_SRCH_RD: begin
                rd_en = 1'b1; rd_addr = mid_c;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_done     <= 1'b0;
            r_acc_pend <= 1'b0;
        end else begin
            r_done     <= (i_cmd.op == iae_pkg::OP_DONE);
            r_acc_pend <= (i_cmd.op == iae_pkg::OP_SUM_RD);

            // summary accumulates the cycle after the read
            if (r_acc_pend) begin
                r_prev <= r_rdata;
                if (r_first) begin
                    r_first  <= 1'b0;
                    r_min    <= r_rdata;
                    r_max    <= r_rdata;
                    r_sum    <= r_rdata;
                    r_sorted <= 1'b1;
                end else begin
                    if (r_rdata < r_min) r_min <= r_rdata;
                    if (r_rdata > r_max) r_max <= r_rdata;
                    r_sum <= r_sum + r_rdata;
                    if (r_prev > r_rdata) r_sorted <= 1'b0;
                end
            end

            case (i_cmd.op)
                iae_pkg::OP_LOAD: begin
                    r_action <= i_action;
                    r_idx    <= XW'(i_index);
                    r_val    <= i_value;
                    r_rv     <= '0;
                    r_found  <= '0;
                    r_min    <= '0;
                    r_max    <= '0;
                    r_sum    <= '0;
                    r_sorted <= 1'b0;
                end
                iae_pkg::OP_PUSH, iae_pkg::OP_INS_FIN: r_cnt <= r_cnt + CW'(1);
                iae_pkg::OP_RD_TOP, iae_pkg::OP_DEL_FIN: r_cnt <= r_cnt - CW'(1);
                iae_pkg::OP_TAKE:     r_rv  <= r_rdata;
                iae_pkg::OP_INS_INIT: r_ptr <= cnt_x;
                iae_pkg::OP_INS_WR:   r_ptr <= r_ptr - XW'(1);
                iae_pkg::OP_DEL_INIT: r_ptr <= r_idx;
                iae_pkg::OP_DEL_WR:   r_ptr <= r_ptr + XW'(1);
                iae_pkg::OP_ROT_RD0:  r_ptr <= '0;
                iae_pkg::OP_ROT_SAVE: r_tmp <= r_rdata;
                iae_pkg::OP_REV_INIT: begin
                    r_ptr <= '0;
                    r_b   <= cnt_x - XW'(1);
                end
                iae_pkg::OP_REV_RDB: r_tmp <= r_rdata;
                iae_pkg::OP_REV_WRB: begin
                    r_ptr <= r_ptr + XW'(1);
                    r_b   <= r_b - XW'(1);
                end
                iae_pkg::OP_SRCH_INIT: begin
                    r_lo <= '0;
                    r_hi <= cnt_x;
                end
                iae_pkg::OP_SRCH_RD: r_mid <= mid_c;
                iae_pkg::OP_SRCH_CMP: begin
                    if (r_rdata == r_val) r_found <= r_mid[iae_pkg::IDX_W-1:0];
                    else if (r_rdata < r_val) r_lo <= r_mid + XW'(1);
                    else r_hi <= r_mid;
                end
                iae_pkg::OP_SUM_INIT: begin
                    r_ptr   <= '0;
                    r_first <= 1'b1;
                end
                iae_pkg::OP_SUM_RD: r_ptr <= r_ptr + XW'(1);
                iae_pkg::OP_DONE:   r_status <= i_cmd.status;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_stat.action    = r_action;
        o_stat.empty     = (r_cnt == '0);
        o_stat.full      = (cnt_x >= XW'(CAPACITY));
        o_stat.idx_ge    = (r_idx >= cnt_x);
        o_stat.idx_gt    = (r_idx > cnt_x);
        o_stat.cnt_gt1   = (cnt_x > XW'(1));
        o_stat.ins_more  = (r_ptr > r_idx);
        o_stat.del_more  = ((r_ptr + XW'(1)) < cnt_x);
        o_stat.rev_more  = (r_ptr < r_b);
        o_stat.srch_more = (r_lo < r_hi);
        o_stat.sum_more  = (r_ptr < cnt_x);
        o_stat.key_eq    = (r_rdata == r_val);
    end

    assign o_done         = r_done;
    assign o_result_value = r_rv;
    assign o_found_index  = r_found;
    assign o_item_count   = cnt_x[iae_pkg::CNT_OUT_W-1:0];
    assign o_smallest     = r_min;
    assign o_largest      = r_max;
    assign o_total        = r_sum;
    assign o_is_sorted    = r_sorted;
    assign o_status       = r_status;

endmodule

// File: hw/rtl/iae_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iae_ctrl
// Controller: decodes the accepted action and sequences the datapath one
// micro-operation per cycle until the result word is issued.
// ----------------------------------------------------------------------------
module iae_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  iae_pkg::t_stat i_stat,
    output iae_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_TAKE, S_INS_RD, S_INS_WR, S_DEL_RD, S_DEL_WR,
        S_ROT_SAVE, S_REV_RDA, S_REV_RDB, S_REV_WRA, S_REV_WRB,
        S_SRCH_RD, S_SRCH_CMP, S_SUM_RD, S_DONE
    } t_state;

    t_state                     r_state, n_state;
    logic [iae_pkg::STAT_W-1:0] r_status, n_status;
    iae_pkg::t_op               op;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        op       = iae_pkg::OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    op       = iae_pkg::OP_LOAD;
                    n_status = iae_pkg::ST_OK;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (i_stat.action)
                    iae_pkg::ACT_PUSH: begin
                        if (i_stat.full) n_status = iae_pkg::ST_FULL;
                        else op = iae_pkg::OP_PUSH;
                    end
                    iae_pkg::ACT_POP: begin
                        if (i_stat.empty) n_status = iae_pkg::ST_EMPTY;
                        else begin
                            op = iae_pkg::OP_RD_TOP; n_state = S_TAKE;
                        end
                    end
                    iae_pkg::ACT_GET: begin
                        if (i_stat.idx_ge) n_status = iae_pkg::ST_RANGE;
                        else begin
                            op = iae_pkg::OP_RD_IDX; n_state = S_TAKE;
                        end
                    end
                    iae_pkg::ACT_SET: begin
                        if (i_stat.idx_ge) n_status = iae_pkg::ST_RANGE;
                        else op = iae_pkg::OP_SET;
                    end
                    iae_pkg::ACT_INSERT: begin
                        if (i_stat.idx_gt) n_status = iae_pkg::ST_RANGE;
                        else if (i_stat.full) n_status = iae_pkg::ST_FULL;
                        else begin
                            op = iae_pkg::OP_INS_INIT; n_state = S_INS_RD;
                        end
                    end
                    iae_pkg::ACT_DELETE: begin
                        if (i_stat.idx_ge) n_status = iae_pkg::ST_RANGE;
                        else begin
                            op = iae_pkg::OP_DEL_INIT; n_state = S_DEL_RD;
                        end
                    end
                    iae_pkg::ACT_REVERSE: begin
                        if (i_stat.cnt_gt1) begin
                            op = iae_pkg::OP_REV_INIT; n_state = S_REV_RDA;
                        end
                    end
                    iae_pkg::ACT_ROTATE: begin
                        if (!i_stat.empty) begin
                            op = iae_pkg::OP_ROT_RD0; n_state = S_ROT_SAVE;
                        end
                    end
                    iae_pkg::ACT_SEARCH: begin
                        op = iae_pkg::OP_SRCH_INIT; n_state = S_SRCH_RD;
                    end
                    iae_pkg::ACT_SUMMARY: begin
                        if (i_stat.empty) n_status = iae_pkg::ST_EMPTY;
                        else begin
                            op = iae_pkg::OP_SUM_INIT; n_state = S_SUM_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_TAKE: begin
                op = iae_pkg::OP_TAKE; n_state = S_DONE;
            end
            S_INS_RD: begin
                if (i_stat.ins_more) begin
                    op = iae_pkg::OP_INS_RD; n_state = S_INS_WR;
                end else begin
                    op = iae_pkg::OP_INS_FIN; n_state = S_DONE;
                end
            end
            S_INS_WR: begin
                op = iae_pkg::OP_INS_WR; n_state = S_INS_RD;
            end
            S_DEL_RD: begin
                // rotate reuses the left-shift walk, then drops the saved head at the end
                if (i_stat.del_more) begin
                    op = iae_pkg::OP_DEL_RD; n_state = S_DEL_WR;
                end else begin
                    op = (i_stat.action == iae_pkg::ACT_ROTATE) ?
                         iae_pkg::OP_ROT_FIN : iae_pkg::OP_DEL_FIN;
                    n_state = S_DONE;
                end
            end
            S_DEL_WR: begin
                op = iae_pkg::OP_DEL_WR; n_state = S_DEL_RD;
            end
            S_ROT_SAVE: begin
                op = iae_pkg::OP_ROT_SAVE; n_state = S_DEL_RD;
            end
            S_REV_RDA: begin
                if (i_stat.rev_more) begin
                    op = iae_pkg::OP_REV_RDA; n_state = S_REV_RDB;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REV_RDB: begin
                op = iae_pkg::OP_REV_RDB; n_state = S_REV_WRA;
            end
            S_REV_WRA: begin
                op = iae_pkg::OP_REV_WRA; n_state = S_REV_WRB;
            end
            S_REV_WRB: begin
                op = iae_pkg::OP_REV_WRB; n_state = S_REV_RDA;
            end
            S_SRCH_RD: begin
                if (i_stat.srch_more) begin
                    op = iae_pkg::OP_SRCH_RD; n_state = S_SRCH_CMP;
                end else begin
                    n_status = iae_pkg::ST_MISSING; n_state = S_DONE;
                end
            end
            S_SRCH_CMP: begin
                op      = iae_pkg::OP_SRCH_CMP;
                n_state = i_stat.key_eq ? S_DONE : S_SRCH_RD;
            end
            S_SUM_RD: begin
                // a final pass with no read after the last read lets the final word accumulate
                if (i_stat.sum_more) op = iae_pkg::OP_SUM_RD;
                else n_state = S_DONE;
            end
            S_DONE: begin
                op = iae_pkg::OP_DONE; n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= iae_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_cmd.op     = op;
    assign o_cmd.status = r_status;
    assign o_busy       = (r_state != S_IDLE);

endmodule

// File: hw/rtl/indexed_array_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_engine_unit
// Fixed-capacity array of signed 32-bit words with a count.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_action, i_index, i_value and raise i_start; the word is taken at
//   the clock edge where i_start is high and o_busy is low. o_busy stays high
//   until the result is issued.
//   One result word per action: all o_* result fields valid for the single
//   cycle o_done is high. The receiver cannot stall; the result is gone
//   after that cycle.
//   Between accept and o_done the controller steps through the word memory:
//     push, set, errors, unused codes: decode only; pop, get: a read, then take
//     insert/delete/rotate: a read and a write per word moved
//     reverse: two reads and two writes per swapped pair
//     search: a read and a compare per probe
//     summarize: a read per word, then a final accumulate step
//   A new action can be accepted in the same cycle o_done is high.
//   Reset (i_rst_n low, synchronous) empties the array; no clearing pass.
// ----------------------------------------------------------------------------
module indexed_array_engine_unit #(
    parameter int CAPACITY = iae_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [iae_pkg::ACT_W-1:0]           i_action,
    input  logic [iae_pkg::IDX_W-1:0]           i_index,
    input  logic signed [iae_pkg::WORD_W-1:0]   i_value,
    output logic                                o_done,
    output logic signed [iae_pkg::WORD_W-1:0]   o_result_value,
    output logic [iae_pkg::IDX_W-1:0]           o_found_index,
    output logic [iae_pkg::CNT_OUT_W-1:0]       o_item_count,
    output logic signed [iae_pkg::WORD_W-1:0]   o_smallest,
    output logic signed [iae_pkg::WORD_W-1:0]   o_largest,
    output logic signed [iae_pkg::WORD_W-1:0]   o_total,
    output logic                                o_is_sorted,
    output logic [iae_pkg::STAT_W-1:0]          o_status
);

    iae_pkg::t_cmd  cmd;
    iae_pkg::t_stat stat;

    iae_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    iae_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_action       (i_action),
        .i_index        (i_index),
        .i_value        (i_value),
        .o_stat         (stat),
        .o_done         (o_done),
        .o_result_value (o_result_value),
        .o_found_index  (o_found_index),
        .o_item_count   (o_item_count),
        .o_smallest     (o_smallest),
        .o_largest      (o_largest),
        .o_total        (o_total),
        .o_is_sorted    (o_is_sorted),
        .o_status       (o_status)
    );

`ifndef ASSERT_OFF
    a_done_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted word did not raise busy");

    a_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result issued while still busy");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_item_count) <= 32'(CAPACITY)))
        else $error("count beyond capacity");
`endif

endmodule
